@@ sv/tlvp_pkg.sv @@
// Shared types and constants of the TLV list parser with item table.
package tlvp_pkg;

  // Input commands
  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_FRAME  = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_TRAIL    = 3'd3,
    ST_HIT      = 3'd4,
    ST_MISS     = 3'd5,
    ST_MISMATCH = 3'd6,
    ST_UNUSED   = 3'd7
  } status_e;

  // Work handed from the parser to the table engine
  typedef enum logic [1:0] {
    OP_NONE     = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_TRAIL    = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic        clear;
    logic [15:0] id;
    logic [15:0] len;
    logic [15:0] off;
  } op_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

endpackage

@@ sv/tlv_list_parser_table_top.sv @@
// Top level of the TLV list parser with item table.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------------------
//   request | in        | push / full       | command, data_byte, last_byte, query_id/length
//   result  | out       | empty / pop       | status, item_id, item_length, payload_offset,
//           |           |                   | entry_index, entry_count
//   config  | in        | cfg_we_i          | cfg_wdata_i (big_endian)
//
// The parser takes one request per cycle while its four-deep work queue has room.
// Plain frame bytes that finish no item and neither open nor end a frame cost no table
// time. A completed item or a lookup in a non-empty table is searched entry by entry,
// each entry read and then compared, through the single table read port until a hit
// (all stored entries on a miss); a completed item meeting a full table is not searched.
// Trailing reports and clears need no search. Reset empties the table at once via the
// entry count; no sweep. A result waiting in the output register holds the engine; the
// parser stalls only once the work queue behind it is full.
module tlv_list_parser_table_top #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] query_id_i,
  input  logic [15:0] query_length_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [15:0] item_id_o,
  output logic [15:0] item_length_o,
  output logic [15:0] payload_offset_o,
  output logic [3:0]  entry_index_o,
  output logic [4:0]  entry_count_o
);
  import tlvp_pkg::*;

  logic q_full, q_empty, q_pop, op_push, accept;
  op_t  op_in, op_out;

  // Take a request only when the queue can hold whatever it issues
  assign full   = q_full;
  assign accept = push && !q_full;

  tlvp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accept_i       (accept),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .query_id_i     (query_id_i),
    .query_length_i (query_length_i),
    .op_push_o      (op_push),
    .op_o           (op_in)
  );

  tlvp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (op_out),
    .empty_o (q_empty)
  );

  tlvp_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_op_i           (op_out),
    .q_pop_o          (q_pop),
    .pop              (pop),
    .empty            (empty),
    .status_o         (status_o),
    .item_id_o        (item_id_o),
    .item_length_o    (item_length_o),
    .payload_offset_o (payload_offset_o),
    .entry_index_o    (entry_index_o),
    .entry_count_o    (entry_count_o)
  );

endmodule

@@ sv/tlvp_front.sv @@
// Byte parser: assembles id, length and payload count, and issues table work.
module tlvp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          accept_i,
  input  logic [1:0]    command_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic [15:0]   query_id_i,
  input  logic [15:0]   query_length_i,
  output logic          op_push_o,
  output tlvp_pkg::op_t op_o
);
  import tlvp_pkg::*;

  typedef enum logic [4:0] {
    PH_ID_A    = 5'b00001,
    PH_ID_B    = 5'b00010,
    PH_LEN_A   = 5'b00100,
    PH_LEN_B   = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] pid_q, pid_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] prem_q, prem_d;
  logic [15:0] poff_q, poff_d;
  logic        big_endian_q, big_endian_d;

  function automatic logic [15:0] place_byte(input logic [15:0] field, input logic [7:0] b,
                                             input logic first, input logic be);
    logic [15:0] r;
    if (first) begin
      r = be ? {b, 8'h00} : {8'h00, b};
    end else begin
      r = be ? (field | {8'h00, b}) : (field | {b, 8'h00});
    end
    return r;
  endfunction

  assign big_endian_d = cfg_we_i ? cfg_wdata_i : big_endian_q;

  always_comb begin
    phase_e      ph;
    logic [15:0] pos, pid, plen, prem, poff, pos_inc;
    logic        complete;
    phase_d   = phase_q;
    pos_d     = pos_q;
    pid_d     = pid_q;
    plen_d    = plen_q;
    prem_d    = prem_q;
    poff_d    = poff_q;
    op_push_o = 1'b0;
    op_o      = '0;
    ph        = phase_q;
    pos       = pos_q;
    pid       = pid_q;
    plen      = plen_q;
    prem      = prem_q;
    poff      = poff_q;
    pos_inc   = 16'd0;
    complete  = 1'b0;
    if (accept_i && command_i == CMD_LOOKUP) begin
      op_push_o = 1'b1;
      op_o.kind = OP_LOOKUP;
      op_o.id   = query_id_i;
      op_o.len  = query_length_i;
    end else if (accept_i && command_i != CMD_NOP) begin
      // a new frame drops any half-built item
      if (command_i == CMD_FRAME) begin
        ph   = PH_ID_A;
        pos  = 16'd0;
        pid  = 16'd0;
        plen = 16'd0;
        prem = 16'd0;
        poff = 16'd0;
      end
      pos_inc = pos + 16'd1;
      unique case (ph)
        PH_ID_A: begin
          pid  = place_byte(16'd0, data_byte_i, 1'b1, big_endian_q);
          plen = 16'd0;
          poff = 16'd0;
          ph   = PH_ID_B;
        end
        PH_ID_B: begin
          pid = place_byte(pid, data_byte_i, 1'b0, big_endian_q);
          ph  = PH_LEN_A;
        end
        PH_LEN_A: begin
          plen = place_byte(16'd0, data_byte_i, 1'b1, big_endian_q);
          ph   = PH_LEN_B;
        end
        PH_LEN_B: begin
          plen = place_byte(plen, data_byte_i, 1'b0, big_endian_q);
          poff = pos_inc;
          prem = plen;
          if (plen == 16'd0) begin
            complete = 1'b1;
            ph       = PH_ID_A;
          end else begin
            ph = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          prem = prem - 16'd1;
          if (prem == 16'd0) begin
            complete = 1'b1;
            ph       = PH_ID_A;
          end
        end
        default: begin
          ph = PH_ID_A;
        end
      endcase
      op_push_o  = complete || last_byte_i || (command_i == CMD_FRAME);
      op_o.clear = (command_i == CMD_FRAME);
      op_o.id    = pid;
      op_o.len   = plen;
      if (complete) begin
        op_o.kind = OP_COMPLETE;
        op_o.off  = poff;
      end else if (last_byte_i) begin
        op_o.kind = OP_TRAIL;
      end else begin
        op_o.kind = OP_NONE;
      end
      if (last_byte_i) begin
        phase_d = PH_ID_A;
        pos_d   = 16'd0;
        pid_d   = 16'd0;
        plen_d  = 16'd0;
        prem_d  = 16'd0;
        poff_d  = 16'd0;
      end else begin
        phase_d = ph;
        pos_d   = pos_inc;
        pid_d   = pid;
        plen_d  = plen;
        prem_d  = prem;
        poff_d  = poff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_ID_A;
      pos_q        <= 16'd0;
      pid_q        <= 16'd0;
      plen_q       <= 16'd0;
      prem_q       <= 16'd0;
      poff_q       <= 16'd0;
      big_endian_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      pid_q        <= pid_d;
      plen_q       <= plen_d;
      prem_q       <= prem_d;
      poff_q       <= poff_d;
      big_endian_q <= big_endian_d;
    end
  end

endmodule

@@ sv/tlvp_queue.sv @@
// Short work queue between the parser and the table engine.
module tlvp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tlvp_pkg::op_t op_i,
  output logic          full_o,
  input  logic          pop_i,
  output tlvp_pkg::op_t op_o,
  output logic          empty_o
);
  import tlvp_pkg::*;

  op_t                  slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign op_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ sv/tlvp_back.sv @@
// Table engine: id table, sequential search, result register.
module tlvp_back #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  tlvp_pkg::op_t q_op_i,
  output logic          q_pop_o,
  input  logic          pop,
  output logic          empty,
  output logic [2:0]    status_o,
  output logic [15:0]   item_id_o,
  output logic [15:0]   item_length_o,
  output logic [15:0]   payload_offset_o,
  output logic [3:0]    entry_index_o,
  output logic [4:0]    entry_count_o
);
  import tlvp_pkg::*;

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [3:0] {
    BK_IDLE     = 4'b0001,
    BK_SCAN_RD  = 4'b0010,
    BK_SCAN_CMP = 4'b0100,
    BK_EMIT     = 4'b1000
  } back_state_e;

  back_state_e     state_q, state_d;
  op_t             op_q, op_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] addr_q, addr_d;

  status_e         res_status_q, res_status_d;
  logic [15:0]     res_id_q, res_id_d;
  logic [15:0]     res_len_q, res_len_d;
  logic [15:0]     res_off_q, res_off_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;
  logic            add_q, add_d;

  logic            out_v_q, out_v_d;
  logic [2:0]      out_status_q;
  logic [15:0]     out_id_q, out_len_q, out_off_q;
  logic [3:0]      out_idx_q;
  logic [4:0]      out_cnt_q;

  logic [15:0]     id_mem  [MAX_ENTRIES];
  logic [15:0]     len_mem [MAX_ENTRIES];
  logic [15:0]     off_mem [MAX_ENTRIES];
  logic [15:0]     rd_id_q, rd_len_q, rd_off_q;

  logic            slot_free, load_out, mem_we;
  logic [CntW-1:0] cnt_after;
  logic [31:0]     cnt_wide, idx_wide;

  assign slot_free = !out_v_q || pop;
  assign load_out  = (state_q == BK_EMIT) && slot_free;
  assign mem_we    = load_out && add_q;
  assign cnt_after = add_q ? cnt_q + 1'b1 : cnt_q;
  assign cnt_wide  = 32'(cnt_after);
  assign idx_wide  = 32'(res_idx_q);
  assign q_pop_o   = (state_q == BK_IDLE) && !q_empty_i;

  always_comb begin
    logic [CntW-1:0] cnt_eff;
    logic            hit;
    state_d      = state_q;
    op_d         = op_q;
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_len_d    = res_len_q;
    res_off_d    = res_off_q;
    res_idx_d    = res_idx_q;
    add_d        = add_q;
    cnt_eff      = q_op_i.clear ? '0 : cnt_q;
    hit          = (rd_id_q == op_q.id);
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          op_d         = q_op_i;
          cnt_d        = cnt_eff;
          addr_d       = '0;
          add_d        = 1'b0;
          res_id_d     = q_op_i.id;
          res_len_d    = q_op_i.len;
          res_off_d    = q_op_i.off;
          res_idx_d    = '0;
          unique case (q_op_i.kind)
            OP_NONE: begin
              state_d = BK_IDLE;
            end
            OP_TRAIL: begin
              res_status_d = ST_TRAIL;
              res_off_d    = 16'd0;
              state_d      = BK_EMIT;
            end
            OP_COMPLETE: begin
              if (cnt_eff >= CntW'(MAX_ENTRIES)) begin
                res_status_d = ST_FULL;
                state_d      = BK_EMIT;
              end else if (cnt_eff == '0) begin
                res_status_d = ST_ADDED;
                add_d        = 1'b1;
                state_d      = BK_EMIT;
              end else begin
                state_d = BK_SCAN_RD;
              end
            end
            OP_LOOKUP: begin
              if (cnt_eff == '0) begin
                res_status_d = ST_MISS;
                res_off_d    = 16'd0;
                state_d      = BK_EMIT;
              end else begin
                state_d = BK_SCAN_RD;
              end
            end
            default: begin
              state_d = BK_IDLE;
            end
          endcase
        end
      end
      BK_SCAN_RD: begin
        state_d = BK_SCAN_CMP;
      end
      BK_SCAN_CMP: begin
        if (hit) begin
          res_idx_d = addr_q;
          state_d   = BK_EMIT;
          if (op_q.kind == OP_LOOKUP) begin
            res_status_d = (rd_len_q == op_q.len) ? ST_HIT : ST_MISMATCH;
            res_len_d    = rd_len_q;
            res_off_d    = rd_off_q;
          end else begin
            res_status_d = ST_DUP;
          end
        end else if (CntW'(addr_q) + 1'b1 == cnt_q) begin
          state_d = BK_EMIT;
          if (op_q.kind == OP_LOOKUP) begin
            res_status_d = ST_MISS;
            res_off_d    = 16'd0;
          end else begin
            res_status_d = ST_ADDED;
            res_idx_d    = cnt_q[IdxW-1:0];
            add_d        = 1'b1;
          end
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = BK_SCAN_RD;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          cnt_d   = cnt_after;
          add_d   = 1'b0;
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (load_out) begin
      out_v_d = 1'b1;
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  // Table storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      id_mem[cnt_q[IdxW-1:0]]  <= res_id_q;
      len_mem[cnt_q[IdxW-1:0]] <= res_len_q;
      off_mem[cnt_q[IdxW-1:0]] <= res_off_q;
    end
    rd_id_q  <= id_mem[addr_q];
    rd_len_q <= len_mem[addr_q];
    rd_off_q <= off_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_len_q    <= res_len_d;
    res_off_q    <= res_off_d;
    res_idx_q    <= res_idx_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_len_q    <= res_len_q;
      out_off_q    <= res_off_q;
      out_idx_q    <= idx_wide[3:0];
      out_cnt_q    <= cnt_wide[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
      add_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      add_q   <= add_d;
      out_v_q <= out_v_d;
    end
  end

  assign empty            = !out_v_q;
  assign status_o         = out_status_q;
  assign item_id_o        = out_id_q;
  assign item_length_o    = out_len_q;
  assign payload_offset_o = out_off_q;
  assign entry_index_o    = out_idx_q;
  assign entry_count_o    = out_cnt_q;

endmodule

@@ sv/tlvp_checker.sv @@
// Port-level checks of the TLV list parser, bound to the top level.
module tlvp_checker #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status_o,
  input logic [15:0] item_id_o,
  input logic [3:0]  entry_index_o,
  input logic [4:0]  entry_count_o
);
  import tlvp_pkg::*;

  localparam logic [31:0] MaxWide = 32'(MAX_ENTRIES);

  // A stalled result keeps its id and status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(item_id_o) && $stable(status_o)))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o != ST_UNUSED))
    else $error("undefined status code");

  // An added item lands in the last filled slot of the table
  a_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_ADDED) |-> (entry_index_o == 4'(entry_count_o - 5'd1)))
    else $error("added slot does not match entry count");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_FULL) |-> (entry_count_o == MaxWide[4:0] && entry_index_o == 4'd0))
    else $error("full report with table not full");

endmodule

bind tlv_list_parser_table_top tlvp_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_tlvp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .status_o      (status_o),
  .item_id_o     (item_id_o),
  .entry_index_o (entry_index_o),
  .entry_count_o (entry_count_o)
);

@@ tb/tb_tlv_list_parser_table_top.sv @@
// Self-checking testbench of the TLV list parser with item table.
module tb_tlv_list_parser_table_top;
  import tlvp_pkg::*;

  localparam int unsigned MAX_ENTRIES   = 16;
  // Random requests (no-ops excluded) to generate after the directed part
  localparam int unsigned RANDOM_TARGET = 900;
  // Quiet cycles after the last result, enough for a miss over a full table
  localparam int unsigned SETTLE_CYCLES = 48;
  // Upper bound on simulated cycles before the watchdog fails the run
  localparam int unsigned CYCLE_LIMIT   = 600_000;
  localparam int unsigned PRINT_LIMIT   = 200;

  // Parser position within one item
  typedef enum int unsigned {
    PH_ID0,
    PH_ID1,
    PH_LEN0,
    PH_LEN1,
    PH_BODY
  } parse_phase_e;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  data;
    logic        last;
    logic [15:0] qid;
    logic [15:0] qlen;
  } tlv_request_t;

  typedef struct {
    status_e     status;
    logic [15:0] id;
    logic [15:0] len;
    logic [15:0] off;
    logic [3:0]  idx;
    logic [4:0]  count;
  } tlv_result_t;

  // DUT connections; every input starts at a known value
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_wdata_i    = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [1:0]  command_i      = CMD_NOP;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        last_byte_i    = 1'b0;
  logic [15:0] query_id_i     = 16'h0000;
  logic [15:0] query_length_i = 16'h0000;
  logic        empty;
  logic        pop            = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] item_id_o;
  logic [15:0] item_length_o;
  logic [15:0] payload_offset_o;
  logic [3:0]  entry_index_o;
  logic [4:0]  entry_count_o;

  // Request stream and expected results
  tlv_request_t request_q[$];
  tlv_result_t  result_q[$];
  tlv_request_t cur_req;
  tlv_result_t  want;

  // Handshake bookkeeping
  logic        req_taken  = 1'b0;
  logic        res_taken  = 1'b0;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  int unsigned send_max   = 0;
  int unsigned recv_max   = 0;

  // Counters
  int unsigned n_queued   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_random   = 0;
  int unsigned n_cfg      = 0;
  int unsigned n_cycles   = 0;
  int unsigned err_count  = 0;
  int unsigned st_seen[8];

  // Predictor state: byte order, item table and parser
  logic         cfg_big   = 1'b0;
  logic [15:0]  tbl_id  [MAX_ENTRIES];
  logic [15:0]  tbl_len [MAX_ENTRIES];
  logic [15:0]  tbl_off [MAX_ENTRIES];
  int unsigned  n_entries = 0;
  logic [15:0]  frame_pos = 16'h0000;
  logic [15:0]  cur_id    = 16'h0000;
  logic [15:0]  cur_len   = 16'h0000;
  logic [15:0]  cur_off   = 16'h0000;
  logic [15:0]  remaining = 16'h0000;
  parse_phase_e prs_phase = PH_ID0;

  // Stimulus-side memory of ids and lengths sent, to aim lookups at the table
  logic [15:0]  seen_ids[$];
  logic [15:0]  known_len[bit [15:0]];
  bit           must_clear = 1'b1;

  tlv_list_parser_table_top #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push             (push),
    .full             (full),
    .command_i        (command_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .query_id_i       (query_id_i),
    .query_length_i   (query_length_i),
    .empty            (empty),
    .pop              (pop),
    .status_o         (status_o),
    .item_id_o        (item_id_o),
    .item_length_o    (item_length_o),
    .payload_offset_o (payload_offset_o),
    .entry_index_o    (entry_index_o),
    .entry_count_o    (entry_count_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Place one header byte into a 16-bit field in the selected byte order
  function automatic logic [15:0] merge_byte(logic [15:0] acc, logic [7:0] b, bit first);
    if (first) return cfg_big ? {b, 8'h00} : {8'h00, b};
    return cfg_big ? (acc | {8'h00, b}) : (acc | {b, 8'h00});
  endfunction

  // Slot of the first stored entry carrying this id, -1 when absent
  function automatic int find_id(logic [15:0] id);
    for (int i = 0; i < n_entries; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic tlv_result_t make_result(status_e st, logic [15:0] id, logic [15:0] len,
                                              logic [15:0] off, logic [3:0] idx);
    tlv_result_t r;
    r.status = st;
    r.id     = id;
    r.len    = len;
    r.off    = off;
    r.idx    = idx;
    r.count  = 5'(n_entries);
    return r;
  endfunction

  // Finished item: full table wins over duplicate, else store it
  function automatic tlv_result_t close_item();
    int slot;
    prs_phase = PH_ID0;
    if (n_entries >= MAX_ENTRIES) return make_result(ST_FULL, cur_id, cur_len, cur_off, 4'h0);
    slot = find_id(cur_id);
    if (slot >= 0) return make_result(ST_DUP, cur_id, cur_len, cur_off, 4'(slot));
    tbl_id[n_entries]  = cur_id;
    tbl_len[n_entries] = cur_len;
    tbl_off[n_entries] = cur_off;
    n_entries++;
    return make_result(ST_ADDED, cur_id, cur_len, cur_off, 4'(n_entries - 1));
  endfunction

  function automatic void rewind_parser();
    frame_pos = 16'h0000;
    prs_phase = PH_ID0;
    cur_id    = 16'h0000;
    cur_len   = 16'h0000;
    remaining = 16'h0000;
    cur_off   = 16'h0000;
  endfunction

  // Advance the predictor by one accepted request and queue any result it causes
  function automatic void predict_request(cmd_e cmd, logic [7:0] b, logic lst,
                                          logic [15:0] qid, logic [15:0] qlen);
    tlv_result_t r;
    bit          made;
    int          slot;
    logic [15:0] pos;
    made = 1'b0;
    if (cmd == CMD_NOP) return;
    if (cmd == CMD_LOOKUP) begin
      slot = find_id(qid);
      if (slot < 0) begin
        r = make_result(ST_MISS, qid, qlen, 16'h0000, 4'h0);
      end else begin
        r = make_result((tbl_len[slot] == qlen) ? ST_HIT : ST_MISMATCH, qid, tbl_len[slot],
                        tbl_off[slot], 4'(slot));
      end
      result_q.push_back(r);
      return;
    end
    if (cmd == CMD_FRAME) begin
      n_entries = 0;
      rewind_parser();
    end
    pos       = frame_pos;
    frame_pos = pos + 16'd1;
    case (prs_phase)
      PH_ID0: begin
        cur_id    = merge_byte(16'h0000, b, 1'b1);
        cur_len   = 16'h0000;
        cur_off   = 16'h0000;
        prs_phase = PH_ID1;
      end
      PH_ID1: begin
        cur_id    = merge_byte(cur_id, b, 1'b0);
        prs_phase = PH_LEN0;
      end
      PH_LEN0: begin
        cur_len   = merge_byte(16'h0000, b, 1'b1);
        prs_phase = PH_LEN1;
      end
      PH_LEN1: begin
        cur_len   = merge_byte(cur_len, b, 1'b0);
        cur_off   = pos + 16'd1;
        remaining = cur_len;
        if (remaining == 16'h0000) begin
          r    = close_item();
          made = 1'b1;
        end else begin
          prs_phase = PH_BODY;
        end
      end
      default: begin
        remaining = remaining - 16'd1;
        if (remaining == 16'h0000) begin
          r    = close_item();
          made = 1'b1;
        end
      end
    endcase
    if (lst) begin
      // an item cut short by the frame end is reported with what was assembled
      if (!made && prs_phase != PH_ID0) begin
        r    = make_result(ST_TRAIL, cur_id, cur_len, 16'h0000, 4'h0);
        made = 1'b1;
      end
      rewind_parser();
    end
    if (made) result_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_req(cmd_e c, logic [7:0] b, logic l, logic [15:0] qid,
                                    logic [15:0] qlen);
    tlv_request_t rq;
    rq.cmd  = c;
    rq.data = b;
    rq.last = l;
    rq.qid  = qid;
    rq.qlen = qlen;
    request_q.push_back(rq);
    n_queued++;
    if (c != CMD_NOP) n_random++;
  endfunction

  // Frame byte; the lookup fields carry junk the block must ignore
  function automatic void queue_byte(cmd_e c, logic [7:0] b, logic l);
    queue_req(c, b, l, 16'($urandom), 16'($urandom));
  endfunction

  // Lookup; data and last carry junk the block must ignore
  function automatic void queue_lookup(logic [15:0] qid, logic [15:0] qlen);
    queue_req(CMD_LOOKUP, 8'($urandom), 1'($urandom), qid, qlen);
  endfunction

  // Lookup aimed mostly at ids already sent, with a right or wrong length
  function automatic void queue_probe();
    logic [15:0] qid;
    logic [15:0] qlen;
    if (seen_ids.size() != 0 && $urandom_range(0, 9) < 7) begin
      qid = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
    end else begin
      qid = 16'($urandom);
    end
    if (known_len.exists(qid) && $urandom_range(0, 1) == 0) qlen = known_len[qid];
    else if ($urandom_range(0, 1) == 0)                       qlen = 16'($urandom_range(0, 12));
    else                                                       qlen = 16'($urandom);
    queue_lookup(qid, qlen);
  endfunction

  function automatic void push_field(ref logic [7:0] fb[$], input logic [15:0] f);
    if (cfg_big) begin
      fb.push_back(f[15:8]);
      fb.push_back(f[7:0]);
    end else begin
      fb.push_back(f[7:0]);
      fb.push_back(f[15:8]);
    end
  endfunction

  // One frame of well-formed items, sometimes cut short or abandoned, with
  // lookups and no-ops mixed in between its bytes
  function automatic void gen_frame(bit clear_first);
    logic [7:0]  fb[$];
    logic [15:0] id;
    logic [15:0] len;
    int unsigned n_items;
    int unsigned cut;
    int unsigned pick;
    bit          abandon;
    n_items = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)       id = 16'($urandom_range(0, 31));
      else if (pick == 7) id = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      else                id = 16'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6)       len = 16'($urandom_range(0, 3));
      else if (pick < 9)  len = 16'($urandom_range(4, 12));
      else                len = 16'($urandom_range(13, 48));
      known_len[id] = len;
      seen_ids.push_back(id);
      push_field(fb, id);
      push_field(fb, len);
      repeat (len) fb.push_back(8'($urandom));
    end
    abandon = 1'b0;
    pick    = $urandom_range(0, 19);
    if (pick < 4) begin
      // frame end falls anywhere, mid-item included
      cut = $urandom_range(1, fb.size() - 1);
      fb  = fb[0:cut - 1];
    end else if (pick == 4) begin
      // no frame end: the next frame restarts with a clear
      cut     = $urandom_range(1, fb.size() - 1);
      fb      = fb[0:cut - 1];
      abandon = 1'b1;
    end
    for (int j = 0; j < fb.size(); j++) begin
      while ($urandom_range(0, 9) == 0) queue_probe();
      if ($urandom_range(0, 29) == 0) begin
        queue_req(CMD_NOP, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      end
      queue_byte((j == 0 && clear_first) ? CMD_FRAME : CMD_BYTE, fb[j],
                 (j == fb.size() - 1) && !abandon);
    end
    must_clear = abandon;
  endfunction

  // Hold until every queued request is accepted and every result has arrived
  task automatic wait_drained();
    do @(negedge clk_i); while (n_accepted != n_queued || result_q.size() != 0);
  endtask

  // Drain, then let the table engine fall quiet
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the byte order register; only called with the block idle
  task automatic write_byte_order(bit v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_big      = v;
    n_cfg++;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    if (err_count < PRINT_LIMIT) begin
      $display("[cycle %0d] mismatch on %s: got 0x%0h, expected 0x%0h",
               n_cycles, what, got, exp_val);
    end
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present requests at the falling edge, one per handshake
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic nxt_push;
    nxt_push = push;
    if (rst_ni) begin
      // drop the request once taken, then idle for its drawn gap
      if (push && req_taken) nxt_push = 1'b0;
      if (!nxt_push) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (request_q.size() != 0) begin
          cur_req         = request_q.pop_front();
          command_i      <= cur_req.cmd;
          data_byte_i    <= cur_req.data;
          last_byte_i    <= cur_req.last;
          query_id_i     <= cur_req.qid;
          query_length_i <= cur_req.qlen;
          nxt_push        = 1'b1;
          send_wait       = $urandom_range(0, send_max);
        end
      end
    end
    push <= nxt_push;
  end

  // Result side: after each result taken, hold pop low for a drawn stall
  always @(negedge clk_i) begin
    logic nxt_pop;
    nxt_pop = pop;
    if (rst_ni) begin
      if (pop && res_taken) begin
        nxt_pop   = 1'b0;
        recv_wait = $urandom_range(0, recv_max);
      end
      if (!nxt_pop) begin
        if (recv_wait != 0) recv_wait--;
        else                nxt_pop = 1'b1;
      end
    end
    pop <= nxt_pop;
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample at the rising edge, check results first, then predict
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      res_taken <= pop && !empty;
      req_taken <= push && !full;
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result, status", status_o, 0);
        end else begin
          want = result_q.pop_front();
          n_checked++;
          st_seen[want.status]++;
          if (status_o !== want.status)
            report_mismatch("status", status_o, want.status);
          if (item_id_o !== want.id)
            report_mismatch("item_id", item_id_o, want.id);
          if (item_length_o !== want.len)
            report_mismatch("item_length", item_length_o, want.len);
          if (payload_offset_o !== want.off)
            report_mismatch("payload_offset", payload_offset_o, want.off);
          if (entry_index_o !== want.idx)
            report_mismatch("entry_index", entry_index_o, want.idx);
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", entry_count_o, want.count);
        end
      end
      if (push && !full) begin
        n_accepted++;
        predict_request(cmd_e'(command_i), data_byte_i, last_byte_i, query_id_i,
                        query_length_i);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               n_cycles, result_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase_no;
    int unsigned n_frames;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, low byte first: lookup in an empty table, extreme ids,
    // a duplicate, hit and length mismatch, frame end inside an id, no-op
    send_max = 3;
    recv_max = 3;
    queue_lookup(16'hFFFF, 16'hFFFF);
    queue_byte(CMD_FRAME, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'hFF, 1'b0);
    queue_byte(CMD_BYTE, 8'hFF, 1'b0);
    queue_byte(CMD_BYTE, 8'h01, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'hFF, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_lookup(16'hFFFF, 16'h0001);
    queue_lookup(16'hFFFF, 16'h0002);
    queue_byte(CMD_BYTE, 8'h34, 1'b1);
    queue_req(CMD_NOP, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF);
    settle();

    // High byte first: frame end inside a length field, then a clean frame
    // that keeps the table because it opens without a clear
    write_byte_order(1'b1);
    queue_byte(CMD_BYTE, 8'h12, 1'b0);
    queue_byte(CMD_BYTE, 8'h34, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b1);
    queue_byte(CMD_BYTE, 8'h56, 1'b0);
    queue_byte(CMD_BYTE, 8'h78, 1'b0);
    queue_byte(CMD_BYTE, 8'h00, 1'b0);
    queue_byte(CMD_BYTE, 8'h02, 1'b0);
    queue_byte(CMD_BYTE, 8'hAA, 1'b0);
    queue_byte(CMD_BYTE, 8'hBB, 1'b1);
    settle();

    // Random phases: new byte order and idling mix each time, frames that
    // fill the table, overflow it and repeat ids
    n_random = 0;
    phase_no = 0;
    while (n_random < RANDOM_TARGET) begin
      write_byte_order((phase_no == 0) ? 1'b0 : 1'($urandom_range(0, 1)));
      send_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      recv_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      n_frames = $urandom_range(3, 7);
      for (int f = 0; f < n_frames && n_random < RANDOM_TARGET; f++) begin
        gen_frame(must_clear || $urandom_range(0, 9) < 6);
        // pause the sender until every result is in, always once in the first phase
        if ((phase_no == 0 && f == 1) || $urandom_range(0, 7) == 0) wait_drained();
      end
      settle();
      phase_no++;
    end

    $display("Covered %0d requests (%0d random, %0d phases), %0d results checked, %0d %s",
             n_accepted, n_random, phase_no, n_checked, n_cfg, "byte-order writes");
    $display("Results: added %0d, duplicate %0d, full %0d, trailing %0d, hit %0d, %s %0d, %s %0d",
             st_seen[ST_ADDED], st_seen[ST_DUP], st_seen[ST_FULL], st_seen[ST_TRAIL],
             st_seen[ST_HIT], "miss", st_seen[ST_MISS], "length mismatch",
             st_seen[ST_MISMATCH]);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
